/* hw/rtl/mlrq_pkg.sv */
// package for the multilevel ready queue: sizes, request codes and shared types
// no dependencies; imported by mlrq_link_mem and multilevel_ready_queue_core
`timescale 1ns / 1ps

package mlrq_pkg;

  localparam int NUM_LEVELS = 8;
  localparam int NUM_TASKS  = 256;

  // field widths of the stream beats
  localparam int REQ_W  = 2;
  localparam int TASK_W = 8;
  localparam int LVLF_W = 3;
  localparam int PRIO_W = 8;

  // internal index widths
  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int LINK_W = $clog2(NUM_TASKS);

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ENQUEUE = 2'd0,
    REQ_DEQUEUE = 2'd1,
    REQ_WAKE    = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  // link memory write port
  typedef struct packed {
    logic              en;
    logic [LINK_W-1:0] addr;
    logic [TASK_W-1:0] data;
  } link_wr_t;

  // link memory read request
  typedef struct packed {
    logic              en;
    logic [LINK_W-1:0] addr;
  } link_rd_t;

endpackage

/* hw/rtl/mlrq_link_mem.sv */
// next-task link memory, one entry per task, one write and one read port
// registered read data; depends on mlrq_pkg
`timescale 1ns / 1ps

module mlrq_link_mem (
  input  logic                      clk,
  input  mlrq_pkg::link_wr_t        wr,
  input  mlrq_pkg::link_rd_t        rd,
  output logic [mlrq_pkg::TASK_W-1:0] rd_data_r
);
  import mlrq_pkg::*;

  logic [TASK_W-1:0] mem [NUM_TASKS];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read port with registered data
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

endmodule

/* hw/rtl/multilevel_ready_queue_core.sv */
// top level of the multilevel ready queue: level head/tail registers and
// dequeue sequencer around the link memory; depends on mlrq_pkg, mlrq_link_mem
`timescale 1ns / 1ps

// Usage
// One request beat on the in_ channel gives exactly one result beat on out_.
// in_tuser carries the request kind (enqueue, dequeue, wake, others ignored);
// in_tdata carries the task and running-task fields.
// out_tuser is the found flag of a dequeue; out_tdata carries the served
// task, the wake level (boosted only for a blocked task) and the preempt flag.
// The result is registered at the edge the request is accepted, and out_
// is driven straight from the output register.
// Enqueue, wake and ignored requests do not hold off the next request. A
// dequeue that leaves its level non-empty holds in_tready low in ST_LINK,
// since the next head comes from the registered link memory read.
// A request is taken only while the output register is empty or being
// emptied in the same cycle, so a stalled receiver holds the queue after
// at most one waiting result.
// Reset marks every level empty; no clearing pass, the block is ready on
// the first cycle after reset.

module multilevel_ready_queue_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // task_id[7:0], task_level[10:8], wake_prio[18:11], task_blocked[19],
  // current_level[22:20], current_priority[30:23], zero fill
  input  logic [mlrq_pkg::IN_DATA_W-1:0]      in_tdata,
  // req_type[1:0]
  input  logic [mlrq_pkg::REQ_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // served_task[7:0], wake_level[10:8], preempt[11], zero fill
  output logic [mlrq_pkg::OUT_DATA_W-1:0]     out_tdata,
  // found[0]
  output logic                                out_tuser
);
  import mlrq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LINK = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // level bookkeeping
  logic [TASK_W-1:0] level_head_r [NUM_LEVELS];
  logic [TASK_W-1:0] level_tail_r [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] level_nonempty_r, level_nonempty_nxt;

  // level whose head waits for the link read
  logic [LVL_W-1:0] link_lvl_r;

  // output register
  logic                  out_valid_r;
  logic [TASK_W-1:0]     out_served_r, out_served_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [LVLF_W-1:0]     out_wlevel_r, out_wlevel_nxt;
  logic                  out_preempt_r, out_preempt_nxt;

  // input fields
  req_t              req_type;
  logic [TASK_W-1:0] task_id;
  logic [LVLF_W-1:0] task_level;
  logic [PRIO_W-1:0] wake_prio;
  logic              task_blocked;
  logic [LVLF_W-1:0] current_level;
  logic [PRIO_W-1:0] current_priority;

  logic accept;
  logic [LVL_W-1:0] lvl_clamped;
  logic [LVL_W-1:0] wake_lvl;
  logic task_in_range;
  logic [PRIO_W:0] mine_sum, cur_sum;

  // dequeue search
  logic             deq_hit;
  logic [LVL_W-1:0] deq_lvl;

  // push control
  logic             push_en;
  logic [LVL_W-1:0] push_lvl;
  logic             link_start;

  link_wr_t          link_wr;
  link_rd_t          link_rd;
  logic [TASK_W-1:0] link_data;

  // unpack the request beat
  assign req_type         = req_t'(in_tuser);
  assign task_id          = in_tdata[7:0];
  assign task_level       = in_tdata[10:8];
  assign wake_prio        = in_tdata[18:11];
  assign task_blocked     = in_tdata[19];
  assign current_level    = in_tdata[22:20];
  assign current_priority = in_tdata[30:23];

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // level saturation and boost
  always_comb begin
    if ({1'b0, task_level} >= (LVLF_W+1)'(NUM_LEVELS)) begin
      lvl_clamped = LVL_W'(NUM_LEVELS - 1);
    end else begin
      lvl_clamped = LVL_W'(task_level);
    end
    if (lvl_clamped != LVL_W'(NUM_LEVELS - 1)) begin
      wake_lvl = lvl_clamped + LVL_W'(1);
    end else begin
      wake_lvl = lvl_clamped;
    end
  end

  assign task_in_range = {1'b0, task_id} < (TASK_W+1)'(NUM_TASKS);
  assign mine_sum = (PRIO_W+1)'(wake_lvl) + (PRIO_W+1)'(wake_prio);
  assign cur_sum  = (PRIO_W+1)'(current_level) + (PRIO_W+1)'(current_priority);

  // highest non-empty level above zero
  always_comb begin
    deq_hit = 1'b0;
    deq_lvl = '0;
    for (int i = 1; i < NUM_LEVELS; i++) begin
      if (level_nonempty_r[i]) begin
        deq_hit = 1'b1;
        deq_lvl = LVL_W'(i);
      end
    end
  end

  // request decode: result beat, push and dequeue control
  always_comb begin
    out_served_nxt     = '0;
    out_found_nxt      = 1'b0;
    out_wlevel_nxt     = '0;
    out_preempt_nxt    = 1'b0;
    push_en            = 1'b0;
    push_lvl           = lvl_clamped;
    link_start         = 1'b0;
    level_nonempty_nxt = level_nonempty_r;
    unique case (req_type)
      REQ_ENQUEUE: begin
        push_en = task_in_range;
      end
      REQ_DEQUEUE: begin
        if (deq_hit) begin
          out_served_nxt = level_head_r[deq_lvl];
          out_found_nxt  = 1'b1;
          if (level_head_r[deq_lvl] == level_tail_r[deq_lvl]) begin
            level_nonempty_nxt[deq_lvl] = 1'b0;
          end else begin
            link_start = 1'b1;
          end
        end
      end
      REQ_WAKE: begin
        if (!task_blocked) begin
          out_wlevel_nxt = task_level;
        end else begin
          push_en         = task_in_range;
          push_lvl        = wake_lvl;
          out_wlevel_nxt  = LVLF_W'(wake_lvl);
          out_preempt_nxt = cur_sum < mine_sum;
        end
      end
      default: begin
      end
    endcase
    if (push_en) begin
      level_nonempty_nxt[push_lvl] = 1'b1;
    end
  end

  // link memory ports
  always_comb begin
    link_wr.en   = accept && push_en && level_nonempty_r[push_lvl];
    link_wr.addr = LINK_W'(level_tail_r[push_lvl]);
    link_wr.data = task_id;
    link_rd.en   = accept && link_start;
    link_rd.addr = LINK_W'(level_head_r[deq_lvl]);
  end

  mlrq_link_mem u_link_mem (
    .clk       (clk),
    .wr        (link_wr),
    .rd        (link_rd),
    .rd_data_r (link_data)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && link_start) begin
          state_nxt = ST_LINK;
        end
      end
      ST_LINK: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      level_nonempty_r <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        level_nonempty_r <= level_nonempty_nxt;
        out_valid_r      <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // head and tail registers
  always_ff @(posedge clk) begin
    if (accept && push_en) begin
      level_tail_r[push_lvl] <= task_id;
      if (!level_nonempty_r[push_lvl]) begin
        level_head_r[push_lvl] <= task_id;
      end
    end
    if (accept && link_start) begin
      link_lvl_r <= deq_lvl;
    end
    if (state_r == ST_LINK) begin
      level_head_r[link_lvl_r] <= link_data;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_served_r  <= out_served_nxt;
      out_found_r   <= out_found_nxt;
      out_wlevel_r  <= out_wlevel_nxt;
      out_preempt_r <= out_preempt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_preempt_r, out_wlevel_r, out_served_r};
  assign out_tuser  = out_found_r;

endmodule
